FILE: design/vma_pkg.sv
// Shared sizes, register map and types for the vector moving average block.
// No dependencies; used by vector_moving_average.
package vma_pkg;

  localparam int MAX_WINDOW  = 256;
  localparam int MAX_VECTOR  = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int RING_DEPTH = MAX_WINDOW * MAX_VECTOR;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int RING_CW    = $clog2(RING_DEPTH + 1);
  localparam int LANE_W     = $clog2(MAX_VECTOR);
  localparam int WIN_W      = 9;
  localparam int VEC_W      = 5;
  localparam int GAIN_W     = 18;
  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_W     = SUM_W + GAIN_W;
  localparam int FRAC_W     = 16;
  localparam int AVG_W      = 25;
  localparam int SHIFTED_W  = PROD_W - FRAC_W;

  localparam logic [WIN_W-1:0]         WINDOW_RESET = WIN_W'(16);
  localparam logic [VEC_W-1:0]         VECTOR_RESET = VEC_W'(1);
  localparam logic signed [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(4096);

  typedef enum logic [1:0] {
    REG_WINDOW = 2'd0,
    REG_VECTOR = 2'd1,
    REG_GAIN   = 2'd2
  } reg_idx_t;

endpackage

FILE: design/vector_moving_average.sv
// Top level of the per-position boxcar moving average over interleaved vectors.
// Depends on vma_pkg (sizes, register map).
//
// Usage:
//   Input words (in_sample) arrive in position order, vector_length per vector,
//   on a valid/ready channel. Each accepted word gives one output word: the
//   window sum of its position scaled by the Q1.16 gain, floored and saturated
//   to 25 bits, with its position and a vector_end flag on the last element.
//   One word per cycle is sustained while out_ready stays high. The path is
//   history RAM read, sum update, gain multiply and saturate, one register
//   stage each; the RAM read port sets the first stage.
//   Each stage moves on when the stage after it is empty or moving, so a
//   stalled receiver fills the pipeline before in_ready drops.
//   The APB port holds window_length (0x0), vector_length (0x4), gain (0x8).
//   A write of either length restarts the filter with an empty history.
//   Reset (rst_n low, synchronous) loads the default registers and empties the
//   history; the history RAM is not swept, a wrap flag masks unwritten slots.
module vector_moving_average
  import vma_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [AVG_W-1:0]       out_average,
  output logic [LANE_W-1:0]             out_position,
  output logic                          out_vector_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [WIN_W-1:0]         wl_r;
  logic [VEC_W-1:0]         vl_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [WIN_W-1:0]         wl_nxt;
  logic [VEC_W-1:0]         vl_nxt;
  reg_idx_t                 reg_idx;
  logic                     cfg_wr;
  logic                     geo_wr;

  logic [RING_AW-1:0]       wp_r;
  logic                     wrap_r;
  logic [LANE_W-1:0]        lane_r;
  logic [RING_CW-1:0]       ring;
  logic [RING_CW-1:0]       wp_inc;
  logic [VEC_W-1:0]         lane_inc;
  logic                     wp_last;
  logic                     lane_last;
  logic                     in_fire;

  logic signed [SUM_W-1:0]  sums_r [MAX_VECTOR];
  logic [SAMPLE_BITS-1:0]   hist_mem [RING_DEPTH];

  logic                          s1_v_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic signed [SAMPLE_BITS-1:0] s1_old_r;
  logic                          s1_oldok_r;
  logic [LANE_W-1:0]             s1_lane_r;
  logic                          s1_end_r;
  logic signed [SUM_W-1:0]       sum_nxt;

  logic                     s2_v_r;
  logic signed [SUM_W-1:0]  s2_sum_r;
  logic [LANE_W-1:0]        s2_lane_r;
  logic                     s2_end_r;
  logic signed [PROD_W-1:0] prod_nxt;

  logic                         s3_v_r;
  logic signed [PROD_W-1:0]     s3_prod_r;
  logic [LANE_W-1:0]            s3_lane_r;
  logic                         s3_end_r;
  logic signed [SHIFTED_W-1:0]  shifted;
  logic signed [AVG_W-1:0]      avg_nxt;

  logic                     out_valid_r;
  logic signed [AVG_W-1:0]  out_average_r;
  logic [LANE_W-1:0]        out_position_r;
  logic                     out_vector_end_r;

  logic out_free, s3_free, s2_free, s3_go, s2_go, s1_go;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign geo_wr  = cfg_wr && (reg_idx == REG_WINDOW || reg_idx == REG_VECTOR);

  always_comb begin
    if (pwdata[WIN_W-1:0] == '0) begin
      wl_nxt = WIN_W'(1);
    end else if (pwdata[WIN_W-1:0] > WIN_W'(MAX_WINDOW)) begin
      wl_nxt = WIN_W'(MAX_WINDOW);
    end else begin
      wl_nxt = pwdata[WIN_W-1:0];
    end
    if (pwdata[VEC_W-1:0] == '0) begin
      vl_nxt = VEC_W'(1);
    end else if (pwdata[VEC_W-1:0] > VEC_W'(MAX_VECTOR)) begin
      vl_nxt = VEC_W'(MAX_VECTOR);
    end else begin
      vl_nxt = pwdata[VEC_W-1:0];
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW: prdata = {{(32-WIN_W){1'b0}}, wl_r};
      REG_VECTOR: prdata = {{(32-VEC_W){1'b0}}, vl_r};
      REG_GAIN:   prdata = {{(32-GAIN_W){gain_r[GAIN_W-1]}}, gain_r};
      default:    prdata = '0;
    endcase
  end

  // handshake chain
  assign out_free = !out_valid_r || out_ready;
  assign s3_go    = s3_v_r && out_free;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_go    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_go    = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_fire  = in_valid && in_ready;

  // ring and lane bookkeeping
  assign ring      = RING_CW'(wl_r * vl_r);
  assign wp_inc    = RING_CW'(wp_r) + RING_CW'(1);
  assign wp_last   = (wp_inc == ring);
  assign lane_inc  = VEC_W'(lane_r) + VEC_W'(1);
  assign lane_last = (lane_inc == vl_r);

  // datapath
  assign sum_nxt = sums_r[s1_lane_r] + SUM_W'(s1_sample_r)
                   - (s1_oldok_r ? SUM_W'(s1_old_r) : SUM_W'(0));
  assign prod_nxt = s2_sum_r * gain_r;
  assign shifted  = s3_prod_r[PROD_W-1:FRAC_W];

  always_comb begin
    if (shifted[SHIFTED_W-1] != shifted[AVG_W-1]) begin
      avg_nxt = shifted[SHIFTED_W-1] ? {1'b1, {(AVG_W-1){1'b0}}} : {1'b0, {(AVG_W-1){1'b1}}};
    end else begin
      avg_nxt = shifted[AVG_W-1:0];
    end
  end

  // history RAM: read-before-write at the write pointer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hist_mem[wp_r] <= in_sample;
      s1_old_r       <= hist_mem[wp_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= WINDOW_RESET;
      vl_r        <= VECTOR_RESET;
      gain_r      <= GAIN_RESET;
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      lane_r      <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_VECTOR; i++) begin
        sums_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_WINDOW: wl_r   <= wl_nxt;
          REG_VECTOR: vl_r   <= vl_nxt;
          REG_GAIN:   gain_r <= pwdata[GAIN_W-1:0];
          default:    ;
        endcase
      end
      if (geo_wr) begin
        wp_r   <= '0;
        wrap_r <= 1'b0;
        lane_r <= '0;
        for (int i = 0; i < MAX_VECTOR; i++) begin
          sums_r[i] <= '0;
        end
      end else begin
        if (in_fire) begin
          wp_r   <= wp_last ? '0 : wp_inc[RING_AW-1:0];
          wrap_r <= wrap_r || wp_last;
          lane_r <= lane_last ? '0 : lane_inc[LANE_W-1:0];
        end
        if (s1_go) begin
          sums_r[s1_lane_r] <= sum_nxt;
        end
      end
      if (in_ready) s1_v_r <= in_valid;
      if (s2_free) s2_v_r <= s1_v_r;
      if (s3_free) s3_v_r <= s2_v_r;
      if (out_free) out_valid_r <= s3_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_oldok_r  <= wrap_r;
      s1_lane_r   <= lane_r;
      s1_end_r    <= lane_last;
    end
    if (s1_go) begin
      s2_sum_r  <= sum_nxt;
      s2_lane_r <= s1_lane_r;
      s2_end_r  <= s1_end_r;
    end
    if (s2_go) begin
      s3_prod_r <= prod_nxt;
      s3_lane_r <= s2_lane_r;
      s3_end_r  <= s2_end_r;
    end
    if (s3_go) begin
      out_average_r    <= avg_nxt;
      out_position_r   <= s3_lane_r;
      out_vector_end_r <= s3_end_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_average    = out_average_r;
  assign out_position   = out_position_r;
  assign out_vector_end = out_vector_end_r;

endmodule
